/* rtl/tlvd_pkg.sv */
// Shared types and constants for the TLV8 fragment-merging decoder.
// Holds the channel payload structs, the queue entry and the queue status.
// No dependencies.
`default_nettype none

package tlvd_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int LEN_W       = 16;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_LIMIT =
    (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [7:0] FRAGMENT_FULL = 8'd255;

  localparam logic KIND_VALUE    = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;
  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_TRUNC    = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } tlvd_in_t;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       item_type;
    logic [7:0]       value_byte;
    logic [LEN_W-1:0] item_length;
    logic             status;
    logic             last_result;
  } tlvd_out_t;

  typedef struct packed {
    logic             en;
    logic [7:0]       item_type;
    logic [LEN_W-1:0] item_length;
    logic             status;
  } tlvd_report_t;

  // one transfer's worth of results, emitted in order: value, first, second
  typedef struct packed {
    logic         val_en;
    logic [7:0]   val_type;
    logic [7:0]   val_byte;
    tlvd_report_t first;
    tlvd_report_t second;
  } tlvd_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } tlvd_qstat_t;

endpackage

`default_nettype wire

/* rtl/tlvd_front.sv */
// Front end: parses the record stream one byte per transfer.
// Classifies each byte and pushes its result set into the queue. Uses tlvd_pkg.
`default_nettype none

module tlvd_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  tlvd_pkg::tlvd_in_t   in_data,
  input  tlvd_pkg::tlvd_qstat_t q_stat,
  output logic                 in_stall,
  output logic                 push,
  output tlvd_pkg::tlvd_entry_t push_entry
);
  import tlvd_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       cur_type_r, cur_type_nxt;
  logic [7:0]       frag_len_r, frag_len_nxt;
  logic [7:0]       consumed_r, consumed_nxt;
  logic [LEN_W-1:0] merged_r, merged_nxt;
  logic             pend_r, pend_nxt;
  logic [7:0]       pend_type_r, pend_type_nxt;

  logic             accept;
  logic             do_close;
  logic [7:0]       close_flen;
  logic [LEN_W-1:0] close_mlen;
  logic [7:0]       cons_inc;
  logic [7:0]       b;
  tlvd_entry_t      ent;

  assign b        = in_data.data_byte;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign cons_inc = consumed_r + 8'd1;

  always_comb begin
    phase_nxt     = phase_r;
    cur_type_nxt  = cur_type_r;
    frag_len_nxt  = frag_len_r;
    consumed_nxt  = consumed_r;
    merged_nxt    = merged_r;
    pend_nxt      = pend_r;
    pend_type_nxt = pend_type_r;
    ent           = '0;
    do_close      = 1'b0;
    close_flen    = frag_len_r;
    close_mlen    = merged_r;

    case (phase_r)
      PH_LEN: begin
        frag_len_nxt = b;
        consumed_nxt = 8'd0;
        if (b == 8'd0) begin
          do_close   = 1'b1;
          close_flen = b;
        end else begin
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        ent.val_en   = 1'b1;
        ent.val_type = cur_type_r;
        ent.val_byte = b;
        close_mlen   = (merged_r < LEN_LIMIT) ? merged_r + LEN_W'(1) : merged_r;
        merged_nxt   = close_mlen;
        consumed_nxt = cons_inc;
        if (cons_inc >= frag_len_r) begin
          do_close = 1'b1;
        end
      end
      default: begin
        if (pend_r && (b != pend_type_r)) begin
          ent.first.en          = 1'b1;
          ent.first.item_type   = pend_type_r;
          ent.first.item_length = merged_r;
          ent.first.status      = STAT_OK;
          merged_nxt            = '0;
        end
        pend_nxt     = 1'b0;
        cur_type_nxt = b;
        frag_len_nxt = 8'd0;
        consumed_nxt = 8'd0;
        phase_nxt    = PH_LEN;
      end
    endcase

    if (do_close) begin
      if (close_flen == FRAGMENT_FULL) begin
        pend_nxt      = 1'b1;
        pend_type_nxt = cur_type_r;
        merged_nxt    = close_mlen;
      end else begin
        ent.first.en          = 1'b1;
        ent.first.item_type   = cur_type_r;
        ent.first.item_length = close_mlen;
        ent.first.status      = STAT_OK;
        merged_nxt            = '0;
        pend_nxt              = 1'b0;
      end
      phase_nxt    = PH_TYPE;
      consumed_nxt = 8'd0;
    end

    if (in_data.end_of_stream) begin
      if (phase_nxt == PH_TYPE) begin
        if (pend_nxt) begin
          ent.second.en          = 1'b1;
          ent.second.item_type   = pend_type_nxt;
          ent.second.item_length = merged_nxt;
          ent.second.status      = STAT_OK;
        end
      end else begin
        ent.second.en          = 1'b1;
        ent.second.item_type   = cur_type_nxt;
        ent.second.item_length = merged_nxt;
        ent.second.status      = STAT_TRUNC;
      end
      phase_nxt     = PH_TYPE;
      cur_type_nxt  = 8'd0;
      frag_len_nxt  = 8'd0;
      consumed_nxt  = 8'd0;
      merged_nxt    = '0;
      pend_nxt      = 1'b0;
      pend_type_nxt = 8'd0;
    end
  end

  assign push       = accept && (ent.val_en || ent.first.en || ent.second.en);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      cur_type_r  <= 8'd0;
      frag_len_r  <= 8'd0;
      consumed_r  <= 8'd0;
      merged_r    <= '0;
      pend_r      <= 1'b0;
      pend_type_r <= 8'd0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      cur_type_r  <= cur_type_nxt;
      frag_len_r  <= frag_len_nxt;
      consumed_r  <= consumed_nxt;
      merged_r    <= merged_nxt;
      pend_r      <= pend_nxt;
      pend_type_r <= pend_type_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tlvd_queue.sv */
// Short queue of result sets between the front and back ends.
// Depth from tlvd_pkg::Q_DEPTH. Uses tlvd_pkg.
`default_nettype none

module tlvd_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  tlvd_pkg::tlvd_entry_t push_entry,
  input  wire                   pop,
  output tlvd_pkg::tlvd_entry_t head,
  output tlvd_pkg::tlvd_qstat_t q_stat
);
  import tlvd_pkg::*;

  tlvd_entry_t        slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.nonempty = (count_r != '0);
  assign do_push         = push && !q_stat.full;
  assign do_pop          = pop && q_stat.nonempty;
  assign head            = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tlvd_back.sv */
// Back end: expands the queue head into result transfers, one per cycle while out_stall is low.
// Drives the output register and pops each entry after its last result. Uses tlvd_pkg.
`default_nettype none

module tlvd_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tlvd_pkg::tlvd_entry_t head,
  input  tlvd_pkg::tlvd_qstat_t q_stat,
  output logic                  pop,
  input  wire                   out_stall,
  output logic                  out_valid,
  output tlvd_pkg::tlvd_out_t   out_data
);
  import tlvd_pkg::*;

  logic [1:0]   sel_r, sel_nxt;
  logic         out_valid_r;
  tlvd_out_t    out_data_r, out_data_nxt;
  logic [2:0]   present;
  logic [2:0]   avail;
  logic [2:0]   rest;
  logic [1:0]   pick;
  logic         last;
  logic         load;
  tlvd_report_t rep;

  assign present = {head.second.en, head.first.en, head.val_en};
  assign load    = !out_valid_r || !out_stall;

  always_comb begin
    case (sel_r)
      2'd0:    avail = present;
      2'd1:    avail = present & 3'b110;
      default: avail = present & 3'b100;
    endcase
    if (avail[0]) begin
      pick = 2'd0;
    end else if (avail[1]) begin
      pick = 2'd1;
    end else begin
      pick = 2'd2;
    end
    case (pick)
      2'd0:    rest = avail & 3'b110;
      2'd1:    rest = avail & 3'b100;
      default: rest = 3'b000;
    endcase
    last = (rest == 3'b000);
    rep  = (pick == 2'd1) ? head.first : head.second;

    out_data_nxt = '0;
    if (pick == 2'd0) begin
      out_data_nxt.result_kind = KIND_VALUE;
      out_data_nxt.item_type   = head.val_type;
      out_data_nxt.value_byte  = head.val_byte;
    end else begin
      out_data_nxt.result_kind = KIND_COMPLETE;
      out_data_nxt.item_type   = rep.item_type;
      out_data_nxt.item_length = rep.item_length;
      out_data_nxt.status      = rep.status;
    end
    out_data_nxt.last_result = last;

    sel_nxt = last ? 2'd0 : pick + 2'd1;
  end

  assign pop       = load && q_stat.nonempty && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= q_stat.nonempty;
      if (q_stat.nonempty) begin
        sel_r <= sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_stat.nonempty) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tlv8_fragment_merging_decoder.sv */
// Top level of the TLV8 fragment-merging decoder.
// Joins tlvd_front, tlvd_queue and tlvd_back. Uses tlvd_pkg.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid, in_stall  | in_data  (tlvd_in_t)
//   out     | output    | out_valid, out_stall| out_data (tlvd_out_t)
//
// The front end takes one byte per cycle while in_stall is low and pushes its result
// set into a four-entry queue; the back end issues one result per cycle from the
// queue head while out_stall is low. A byte yields at most two results.
// The first result passes through a queue slot and then the output register before out_valid rises.
// in_stall rises only when the queue is full.
// Reset clears parser state, queue pointers and the output valid.
`default_nettype none

module tlv8_fragment_merging_decoder (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  tlvd_pkg::tlvd_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output tlvd_pkg::tlvd_out_t out_data
);
  import tlvd_pkg::*;

  tlvd_qstat_t q_stat;
  tlvd_entry_t push_entry;
  tlvd_entry_t head;
  logic        push;
  logic        pop;

  tlvd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  tlvd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  tlvd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for the TLV8 fragment-merging decoder: directed records, a merged 255-byte
// fragment and random record streams, all checked in order.
// Depends on tlvd_pkg and tlv8_fragment_merging_decoder.
module tb;
  import tlvd_pkg::*;

  typedef enum logic [1:0] {AWAIT_TYPE, AWAIT_LEN, IN_VALUE} parse_phase_t;

  class tlv_decode_board;
    tlvd_out_t        expected_results[$];
    tlvd_out_t        step_results[$];
    int               mismatches;
    parse_phase_t     phase;
    logic [7:0]       cur_type;
    logic [7:0]       frag_len;
    logic [7:0]       frag_seen;
    logic [7:0]       open_type;
    logic [LEN_W-1:0] merged_len;
    logic             open_item;

    function new();
      mismatches = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      phase      = AWAIT_TYPE;
      cur_type   = 8'h00;
      frag_len   = 8'h00;
      frag_seen  = 8'h00;
      merged_len = '0;
      open_item  = 1'b0;
      open_type  = 8'h00;
    endfunction

    function void add_result(logic kind, logic [7:0] code, logic [7:0] vbyte,
                             logic [LEN_W-1:0] len, logic stat);
      tlvd_out_t r;
      r.result_kind = kind;
      r.item_type   = code;
      r.value_byte  = vbyte;
      r.item_length = len;
      r.status      = stat;
      r.last_result = 1'b0;
      step_results = {step_results, r};
    endfunction

    function void close_fragment();
      if (frag_len == FRAGMENT_FULL) begin
        open_item = 1'b1;
        open_type = cur_type;
      end else begin
        add_result(KIND_COMPLETE, cur_type, 8'h00, merged_len, STAT_OK);
        merged_len = '0;
        open_item  = 1'b0;
      end
      phase     = AWAIT_TYPE;
      frag_seen = 8'h00;
    endfunction

    function void note_byte(tlvd_in_t item);
      logic [7:0] b;
      b = item.data_byte;
      step_results.delete();
      case (phase)
        AWAIT_LEN: begin
          frag_len  = b;
          frag_seen = 8'h00;
          if (b == 8'h00) close_fragment();
          else phase = IN_VALUE;
        end
        IN_VALUE: begin
          add_result(KIND_VALUE, cur_type, b, '0, STAT_OK);
          if (merged_len < LEN_LIMIT) merged_len++;
          frag_seen++;
          if (frag_seen >= frag_len) close_fragment();
        end
        default: begin
          if (open_item && b != open_type) begin
            add_result(KIND_COMPLETE, open_type, 8'h00, merged_len, STAT_OK);
            merged_len = '0;
          end
          open_item = 1'b0;
          cur_type  = b;
          frag_len  = 8'h00;
          frag_seen = 8'h00;
          phase     = AWAIT_LEN;
        end
      endcase
      if (item.end_of_stream) begin
        if (phase == AWAIT_TYPE) begin
          if (open_item) add_result(KIND_COMPLETE, open_type, 8'h00, merged_len, STAT_OK);
        end else begin
          add_result(KIND_COMPLETE, cur_type, 8'h00, merged_len, STAT_TRUNC);
        end
        clear_parser();
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].last_result = 1'b1;
      expected_results = {expected_results, step_results};
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(tlvd_out_t got);
      tlvd_out_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d type %0d", got.result_kind,
               got.item_type);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("item_type", want.item_type, got.item_type);
      check_field("value_byte", want.value_byte, got.value_byte);
      check_field("item_length", want.item_length, got.item_length);
      check_field("status", want.status, got.status);
      check_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tlvd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tlvd_out_t out_data;
  logic      idle_on = 1'b1;

  tlv_decode_board board;

  tlv8_fragment_merging_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int       gap;
    tlvd_in_t item;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    item.data_byte     = b;
    item.end_of_stream = eos;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    board.note_byte(item);
  endtask

  // eos_at: -1 none, 0 type byte, 1 length byte, k+2 value byte k
  task automatic send_record(input logic [7:0] code, input int len, input int eos_at);
    int i;
    send_byte(code, eos_at == 0);
    if (eos_at == 0) return;
    send_byte(len[7:0], eos_at == 1);
    if (eos_at == 1) return;
    for (i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), eos_at == i + 2);
      if (eos_at == i + 2) return;
    end
  endtask

  initial begin
    int hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = idle_on ? $urandom_range(0, 12) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_data);
    end
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int         sent;
    int         len;
    int         eos_at;
    int         pick;
    logic [7:0] code;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h44, 1'b0); send_byte(8'h03, 1'b1);
    send_byte(8'h21, 1'b0); send_byte(8'h04, 1'b0); send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h10, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h7E, 1'b1);
    send_byte(8'h66, 1'b0); send_byte(8'h00, 1'b1);

    // merge a second fragment onto a full one, then cut it off
    send_record(8'h07, 255, -1);
    send_record(8'h07, 255, 3);

    sent = 0;
    while (sent < 175) begin
      if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 99) < 8) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        sent++;
        continue;
      end
      if ($urandom_range(0, 1) == 1) code = 8'($urandom_range(0, 3));
      else code = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 0;
      else if (pick < 90) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 40);
      eos_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 1) : -1;
      send_record(code, len, eos_at);
      sent += (eos_at < 0) ? len + 2 : eos_at + 1;
    end
    idle_on = 1'b1;

    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
